// File: rtl/core/qxmm_pkg.sv
package qxmm_pkg;

   localparam int NROT     = 4;
   localparam int IN_W     = 32;
   localparam int K_W      = 29;
   localparam int FRAC_SH  = 28;             // scale of 1.0 in the Q2.28 mixing terms
   localparam int PROD_W   = IN_W + K_W + 1; // signed product of a moment and sqrt2
   localparam int HALF_W   = IN_W + 1;       // thrust +/- yaw
   localparam int SUM_W    = PROD_W + 1;     // full mix sum
   localparam int DROP_W   = 14;             // mix sum bits below the radicand
   localparam int SPEED_W  = 24;
   localparam int RAD_W    = 2 * SPEED_W;
   localparam int SQ_STEP  = 2;              // root bits resolved per pipeline stage
   localparam int SQ_NS    = SPEED_W / SQ_STEP;

   // sqrt2 in unsigned Q1.28
   localparam logic [K_W-1:0] SQRT2_Q28 = K_W'(379625062);

   typedef logic [NROT-1:0][RAD_W-1:0]   rad_vec_type;
   typedef logic [NROT-1:0][SPEED_W-1:0] speed_vec_type;

   typedef struct packed {
      rad_vec_type     rad;
      logic [NROT-1:0] clamped;
   } mix_out_type;

   typedef struct packed {
      speed_vec_type   speed;
      logic [NROT-1:0] clamped;
   } sqrt_out_type;

endpackage

// File: rtl/core/qxmm_mix.sv
module qxmm_mix import qxmm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [IN_W-1:0] thrust,
   input  logic signed [IN_W-1:0] moment_x,
   input  logic signed [IN_W-1:0] moment_y,
   input  logic signed [IN_W-1:0] moment_z,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mix_out_type            out_item
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     adv1, adv2, adv3;
   logic signed [IN_W-1:0]   t_ff, z_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [HALF_W-1:0] tpz_ff, tmz_ff, tpz_in, tmz_in;
   logic signed [PROD_W-1:0] spp_ff, dpp_ff, spp_in, dpp_in;
   logic signed [SUM_W-1:0]  hi_p, hi_m, lo_s, lo_d;
   logic signed [SUM_W-1:0]  sum [NROT];
   mix_out_type              res_ff, res_in;
   logic [NROT-1:0]          rad_nz;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // stage 1: sqrt2 products
   assign px_in = PROD_W'($signed(moment_x) * $signed({1'b0, SQRT2_Q28}));
   assign py_in = PROD_W'($signed(moment_y) * $signed({1'b0, SQRT2_Q28}));

   // stage 2: pre-adds shared between rotor rows
   assign tpz_in = {t_ff[IN_W-1], t_ff} + {z_ff[IN_W-1], z_ff};
   assign tmz_in = {t_ff[IN_W-1], t_ff} - {z_ff[IN_W-1], z_ff};
   assign spp_in = px_ff + py_ff;
   assign dpp_in = px_ff - py_ff;

   // stage 3: row sums, clamp and radicand
   assign hi_p = {{(SUM_W-HALF_W-FRAC_SH){tpz_ff[HALF_W-1]}}, tpz_ff, FRAC_SH'(0)};
   assign hi_m = {{(SUM_W-HALF_W-FRAC_SH){tmz_ff[HALF_W-1]}}, tmz_ff, FRAC_SH'(0)};
   assign lo_s = {spp_ff[PROD_W-1], spp_ff};
   assign lo_d = {dpp_ff[PROD_W-1], dpp_ff};

   always_comb begin
      sum[0] = hi_p - lo_d;
      sum[1] = hi_m - lo_s;
      sum[2] = hi_p + lo_d;
      sum[3] = hi_m + lo_s;
      for (int r = 0; r < NROT; r++) begin
         res_in.clamped[r] = sum[r][SUM_W-1];
         res_in.rad[r]     = sum[r][SUM_W-1] ? '0 : sum[r][DROP_W +: RAD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         t_ff  <= thrust;
         z_ff  <= moment_z;
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (adv2 && v1_ff) begin
         tpz_ff <= tpz_in;
         tmz_ff <= tmz_in;
         spp_ff <= spp_in;
         dpp_ff <= dpp_in;
      end
      if (adv3 && v2_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = res_ff;

   always_comb begin
      for (int r = 0; r < NROT; r++) begin
         rad_nz[r] = |res_ff.rad[r];
      end
   end

   a_clamp_zero: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (res_ff.clamped & rad_nz) == '0)
      else $error("clamped rotor carries a nonzero radicand");

   a_hold_stage1: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !adv2 |=> v1_ff && $stable(px_ff) && $stable(t_ff))
      else $error("stage 1 item lost under stall");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> v1_ff && v2_ff && v3_ff)
      else $error("input stalled with a bubble in the mixer");

endmodule

// File: rtl/core/qxmm_sqrt.sv
module qxmm_sqrt import qxmm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  mix_out_type  in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output sqrt_out_type out_item
);

   // index 0 is the stage input, index s+1 the register of stage s
   logic            valid_w [SQ_NS+1];
   logic            rdy     [SQ_NS+1];
   rad_vec_type     rem_w   [SQ_NS+1];
   speed_vec_type   root_w  [SQ_NS+1];
   logic [NROT-1:0] mask_w  [SQ_NS+1];
   logic [NROT-1:0] bound_ok;

   assign valid_w[0]  = in_valid;
   assign rem_w[0]    = in_item.rad;
   assign root_w[0]   = '0;
   assign mask_w[0]   = in_item.clamped;
   assign rdy[SQ_NS]  = out_ready;
   assign in_ready    = rdy[0];

   for (genvar s = 0; s < SQ_NS; s++) begin : g_stage
      localparam int HI = SPEED_W - 1 - SQ_STEP * s;

      logic            valid_ff;
      rad_vec_type     rem_ff, rem_in;
      speed_vec_type   root_ff, root_in;
      logic [NROT-1:0] mask_ff;

      assign rdy[s] = !valid_ff || rdy[s+1];

      // restoring square root: try bit i, keep it when (q + 2^i)^2 <= radicand
      always_comb begin
         logic [RAD_W-1:0]   r;
         logic [SPEED_W-1:0] q;
         logic [RAD_W:0]     trial;
         for (int l = 0; l < NROT; l++) begin
            r = rem_w[s][l];
            q = root_w[s][l];
            for (int j = 0; j < SQ_STEP; j++) begin
               trial = ((RAD_W+1)'(q) << (HI - j + 1)) | ((RAD_W+1)'(1) << (2 * (HI - j)));
               if ({1'b0, r} >= trial) begin
                  r = r - RAD_W'(trial);
                  q = q | (SPEED_W'(1) << (HI - j));
               end
            end
            rem_in[l]  = r;
            root_in[l] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff <= valid_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && valid_w[s]) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            mask_ff <= mask_w[s];
         end
      end

      assign valid_w[s+1] = valid_ff;
      assign rem_w[s+1]   = rem_ff;
      assign root_w[s+1]  = root_ff;
      assign mask_w[s+1]  = mask_ff;
   end

   // a 48-bit radicand always yields a root below 2^24, so no saturation is reachable
   assign out_valid        = valid_w[SQ_NS];
   assign out_item.speed   = root_w[SQ_NS];
   assign out_item.clamped = mask_w[SQ_NS];

   always_comb begin
      for (int l = 0; l < NROT; l++) begin
         bound_ok[l] = rem_w[SQ_NS][l] <= {root_w[SQ_NS][l], 1'b0};
      end
   end

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> &bound_ok)
      else $error("square root remainder exceeds 2*root");

   a_clamp_speed: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_item.clamped[0] |-> out_item.speed[0] == '0)
      else $error("clamped rotor 0 has nonzero speed");

   a_ready_first: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> valid_w[1] && valid_w[SQ_NS])
      else $error("sqrt input stalled with an empty first stage");

endmodule

// File: rtl/core/quad_x_motor_mixer_sqrt_unit.sv
// Pipeline: 3 mix stages, then 12 square-root stages, from req accept to rsp valid.
// Throughput: one item per cycle while rsp_tready holds; the 12-stage root pipeline resolves 2 bits per stage.
// Each stage holds its item under backpressure and takes a new one while a bubble sits ahead.
// Reset (synchronous) clears only the stage valid bits; the datapath registers are not reset.
module quad_x_motor_mixer_sqrt_unit import qxmm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // thrust, moment_x, moment_y, moment_z (32 bits each)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // speed_motor_0, _1, _2, _3 (24 bits each)
   output logic [3:0]   rsp_tuser   // clamped_mask
);

   logic         mix_valid, mix_ready;
   mix_out_type  mix_item;
   sqrt_out_type sq_item;

   qxmm_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .thrust    ($signed(req_tdata[31:0])),
      .moment_x  ($signed(req_tdata[63:32])),
      .moment_y  ($signed(req_tdata[95:64])),
      .moment_z  ($signed(req_tdata[127:96])),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_item  (mix_item)
   );

   qxmm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_item   (mix_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (sq_item)
   );

   assign rsp_tdata = {sq_item.speed[3], sq_item.speed[2], sq_item.speed[1], sq_item.speed[0]};
   assign rsp_tuser = sq_item.clamped;

endmodule
